// File: rtl/abd_pkg.sv
// shared types, constants and sizes for the arcade bus address decoder
package abd_pkg;

    localparam int ROM_WORDS = 16384;
    localparam int ROM_AW    = $clog2(ROM_WORDS);
    localparam int RAM_WORDS = 4096;
    localparam int RAM_AW    = $clog2(RAM_WORDS);

    localparam logic [15:0] ROM_LIMIT = 16'(ROM_WORDS);

    localparam logic [7:0] BYTE_OPEN_LOW  = 8'hBF;
    localparam logic [7:0] BYTE_OPEN_HIGH = 8'hFF;
    localparam logic [7:0] BYTE_ZERO      = 8'h00;
    localparam logic [7:0] NIBBLE_MASK    = 8'h0F;

    // bus access kinds
    typedef enum logic [2:0] {
        MODE_MEM_RD = 3'd0,
        MODE_MEM_WR = 3'd1,
        MODE_IO_RD  = 3'd2,
        MODE_IO_WR  = 3'd3,
        MODE_ROM_LD = 3'd4
    } mode_t;

    // where the read byte of a transfer comes from
    typedef enum logic [1:0] {
        SRC_CONST = 2'd0,
        SRC_ROM   = 2'd1,
        SRC_RAM   = 2'd2
    } src_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ROM_AW-1:0] addr;
        logic [7:0]        wdata;
    } rom_req_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        wdata;
    } ram_req_t;

    // decoded transfer handed from the issue stage to the result stage
    typedef struct packed {
        src_t       src;
        logic [7:0] const_byte;
        logic [3:0] latch;
        logic [7:0] vector;
    } issue_t;

endpackage

// File: rtl/abd_if.sv
// request and response channel interfaces
interface abd_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  player_inputs_a;
    logic [7:0]  player_inputs_b;

    modport source (
        output valid, mode, address, write_data, player_inputs_a, player_inputs_b,
        input  ready
    );
    modport sink (
        input  valid, mode, address, write_data, player_inputs_a, player_inputs_b,
        output ready
    );
endinterface

interface abd_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_enable;
    logic       audio_enable;
    logic       screen_flip;
    logic       coin_meter;
    logic [7:0] irq_vector;

    modport source (
        output valid, read_data, irq_enable, audio_enable, screen_flip, coin_meter,
               irq_vector,
        input  ready
    );
    modport sink (
        input  valid, read_data, irq_enable, audio_enable, screen_flip, coin_meter,
               irq_vector,
        output ready
    );
endinterface

// File: rtl/abd_ram.sv
// generic single-port ram with registered read
module abd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[addr] <= wdata;
        end
        // read data holds until the next read
        if (en && !we)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/abd_issue.sv
// issue stage: address decode, memory requests, control latch and vector byte
module abd_issue (
    input  logic              clk,
    input  logic              rst_n,
    abd_req_if.sink           req,
    input  logic              stage_free,
    input  logic [7:0]        dip,
    output logic              fire,
    output abd_pkg::issue_t   item,
    output abd_pkg::rom_req_t rom_req,
    output abd_pkg::ram_req_t ram_req
);
    import abd_pkg::*;

    logic [3:0] latch_reg;
    logic [3:0] latch_next;
    logic [7:0] vector_reg;
    logic [7:0] vector_next;
    logic [15:0] a;
    logic [7:0]  d;

    assign req.ready = stage_free;
    assign fire      = req.valid && req.ready;
    assign a         = req.address;
    assign d         = req.write_data;

    always_comb
    begin
        latch_next      = latch_reg;
        vector_next     = vector_reg;
        item.src        = SRC_CONST;
        item.const_byte = BYTE_ZERO;
        rom_req.en      = 1'b0;
        rom_req.we      = 1'b0;
        rom_req.addr    = a[ROM_AW-1:0];
        rom_req.wdata   = d;
        ram_req.en      = 1'b0;
        ram_req.we      = 1'b0;
        ram_req.addr    = a[RAM_AW-1:0];
        ram_req.wdata   = d;

        case (mode_t'(req.mode))
            MODE_MEM_RD:
            begin
                if (a[15:14] == 2'b00)
                begin
                    if (a < ROM_LIMIT)
                    begin
                        item.src   = SRC_ROM;
                        rom_req.en = 1'b1;
                    end
                    else
                    begin
                        item.const_byte = BYTE_OPEN_HIGH;
                    end
                end
                else if (a[15:12] == 4'h4)
                begin
                    // 0x4800-0x4bff is open bus
                    if (a[11:10] == 2'b10)
                    begin
                        item.const_byte = BYTE_OPEN_LOW;
                    end
                    else
                    begin
                        item.src   = SRC_RAM;
                        ram_req.en = 1'b1;
                    end
                end
                else if (a[15:8] == 8'h50 && a[7:6] == 2'b00)
                begin
                    item.const_byte = req.player_inputs_a;
                end
                else if (a[15:8] == 8'h50 && a[7:6] == 2'b01)
                begin
                    item.const_byte = req.player_inputs_b;
                end
                else if (a[15:8] == 8'h50 && a[7:6] == 2'b10)
                begin
                    item.const_byte = dip;
                end
                else
                begin
                    item.const_byte = BYTE_OPEN_HIGH;
                end
            end
            MODE_MEM_WR:
            begin
                if (a[15:12] == 4'h4 && a[11:10] != 2'b10)
                begin
                    ram_req.en = 1'b1;
                    ram_req.we = 1'b1;
                end
                else if (a[15:3] == 13'h0A00)
                begin
                    case (a[2:0])
                        3'd0:    latch_next[0] = d[0];
                        3'd1:    latch_next[1] = d[0];
                        3'd3:    latch_next[2] = d[0];
                        3'd7:    latch_next[3] = d[0];
                        default: latch_next = latch_reg;
                    endcase
                end
                else if (a[15:6] == 10'h141 && !(a[5] && a[4]))
                begin
                    // voice and sprite position bytes live in the unused
                    // 0x800 window of the work ram
                    ram_req.en   = 1'b1;
                    ram_req.we   = 1'b1;
                    ram_req.addr = {2'b10, 4'b0000, a[5:0]};
                    if (!a[5])
                    begin
                        ram_req.wdata = d & NIBBLE_MASK;
                    end
                end
            end
            MODE_IO_RD:
            begin
                item.const_byte = BYTE_OPEN_HIGH;
            end
            MODE_IO_WR:
            begin
                if (a[7:0] == 8'h00)
                begin
                    vector_next = d;
                end
            end
            MODE_ROM_LD:
            begin
                if (a < ROM_LIMIT)
                begin
                    rom_req.en = 1'b1;
                    rom_req.we = 1'b1;
                end
            end
            default:
            begin
                item.const_byte = BYTE_ZERO;
            end
        endcase

        if (!fire)
        begin
            rom_req.en = 1'b0;
            ram_req.en = 1'b0;
        end

        item.latch  = latch_next;
        item.vector = vector_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg  <= 4'b0000;
            vector_reg <= 8'h00;
        end
        else if (fire)
        begin
            latch_reg  <= latch_next;
            vector_reg <= vector_next;
        end
    end

endmodule

// File: rtl/abd_result.sv
// result stage: waits on memory read data, then an output register
module abd_result (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  abd_pkg::issue_t item,
    input  logic [7:0]      rom_rdata,
    input  logic [7:0]      ram_rdata,
    output logic            stage_free,
    abd_rsp_if.source       rsp
);
    import abd_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    issue_t     s1_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_data_reg;
    logic [3:0] out_latch_reg;
    logic [7:0] out_vector_reg;
    logic [7:0] byte_sel;
    logic       out_free;
    logic       s1_move;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign s1_move    = s1_valid_reg && out_free;
    assign stage_free = !s1_valid_reg || out_free;

    always_comb
    begin
        case (s1_reg.src)
            SRC_ROM: byte_sel = rom_rdata;
            SRC_RAM: byte_sel = ram_rdata;
            default: byte_sel = s1_reg.const_byte;
        endcase

        s1_valid_next = s1_valid_reg;
        if (fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_reg <= item;
        end
        if (s1_move)
        begin
            out_data_reg   <= byte_sel;
            out_latch_reg  <= s1_reg.latch;
            out_vector_reg <= s1_reg.vector;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = out_data_reg;
    assign rsp.irq_enable   = out_latch_reg[0];
    assign rsp.audio_enable = out_latch_reg[1];
    assign rsp.screen_flip  = out_latch_reg[2];
    assign rsp.coin_meter   = out_latch_reg[3];
    assign rsp.irq_vector   = out_vector_reg;

endmodule

// File: rtl/arcade_bus_address_decoder_unit.sv
// top level of the arcade bus address decoder
//
//  port      | dir  | carries
//  ----------+------+--------------------------------------------------
//  req       | in   | bus access: mode, address, write_data, player inputs
//  rsp       | out  | read_data, four latch lines, irq_vector
//  cfg_we    | in   | dip switch byte write enable
//  cfg_wdata | in   | dip switch byte
//
// one transfer per cycle sustained while rsp.ready is high; rsp comes from an output register
// fed, for memory reads, by the registered read of the program rom and work ram
// the work ram holds tile, palette, scratch, sprite attribute, voice and
// sprite position bytes; no clearing pass, ready right after reset
// rsp stalls back up through the result stage to req.ready
module arcade_bus_address_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    abd_req_if.sink    req,
    abd_rsp_if.source  rsp,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);
    import abd_pkg::*;

    logic     [7:0] dip_reg;
    logic           stage_free;
    logic           fire;
    issue_t         item;
    rom_req_t       rom_req;
    ram_req_t       ram_req;
    logic     [7:0] rom_rdata;
    logic     [7:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dip_reg <= 8'h00;
        end
        else if (cfg_we)
        begin
            dip_reg <= cfg_wdata;
        end
    end

    abd_issue u_issue (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .stage_free (stage_free),
        .dip        (dip_reg),
        .fire       (fire),
        .item       (item),
        .rom_req    (rom_req),
        .ram_req    (ram_req)
    );

    abd_ram #(
        .WIDTH (8),
        .DEPTH (ROM_WORDS)
    ) u_rom (
        .clk   (clk),
        .en    (rom_req.en),
        .we    (rom_req.we),
        .addr  (rom_req.addr),
        .wdata (rom_req.wdata),
        .rdata (rom_rdata)
    );

    abd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_WORDS)
    ) u_work_ram (
        .clk   (clk),
        .en    (ram_req.en),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    abd_result u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item),
        .rom_rdata  (rom_rdata),
        .ram_rdata  (ram_rdata),
        .stage_free (stage_free),
        .rsp        (rsp)
    );

endmodule

// File: tb/sv/arcade_bus_address_decoder_unit_tb.sv
// self-checking testbench for the arcade bus address decoder: directed and random bus accesses
`timescale 1ns / 100ps

module arcade_bus_address_decoder_unit_tb;

    import abd_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 4;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 320;
    localparam int PACE_SPAN    = 40;
    localparam int MAX_PRINTS   = 50;

    // memory map
    localparam logic [15:0] TILE_BASE       = 16'h4000;
    localparam logic [15:0] PAL_BASE        = 16'h4400;
    localparam logic [15:0] OPEN_BASE       = 16'h4800;
    localparam logic [15:0] SCR_BASE        = 16'h4C00;
    localparam logic [15:0] ATTR_BASE       = 16'h4FF0;
    localparam logic [15:0] PIN_A_BASE      = 16'h5000;
    localparam logic [15:0] PIN_B_BASE      = 16'h5040;
    localparam logic [15:0] DIP_BASE        = 16'h5080;
    localparam logic [15:0] HIGH_BASE       = 16'h50C0;
    localparam logic [15:0] VOICE_END       = 16'h505F;
    localparam logic [15:0] XY_BASE         = 16'h5060;
    localparam logic [15:0] XY_END          = 16'h506F;
    localparam logic [15:0] LATCH_IRQ_ADDR  = 16'h5000;
    localparam logic [15:0] LATCH_SND_ADDR  = 16'h5001;
    localparam logic [15:0] LATCH_SPARE     = 16'h5002;
    localparam logic [15:0] LATCH_FLIP_ADDR = 16'h5003;
    localparam logic [15:0] LATCH_COIN_ADDR = 16'h5007;
    localparam logic [7:0]  VECTOR_PORT     = 8'h00;

    // mode codes beyond the package enum do nothing
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef enum int { PACE_STREAM, PACE_MIXED, PACE_CHOKED } pace_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] address;
        logic [7:0]  wdata;
        logic [7:0]  in_a;
        logic [7:0]  in_b;
    } bus_access_t;

    typedef struct packed {
        logic [7:0] rd;
        logic       irq;
        logic       audio;
        logic       flip;
        logic       coin;
        logic [7:0] vec;
    } bus_result_t;

    class decoder_scoreboard;
        logic [7:0]  rom_img     [ROM_WORDS];
        logic [7:0]  tile_img    [1024];
        logic [7:0]  palette_img [1024];
        logic [7:0]  scratch_img [1008];
        logic [7:0]  attr_img    [16];
        logic [3:0]  voice_img   [32];
        logic [7:0]  xy_img      [16];
        logic [3:0]  latch_q;
        logic [7:0]  vector_q;
        logic [7:0]  dip_byte;
        bus_result_t awaited [$];
        int          seen;
        int          errors;

        function new();
            latch_q  = 4'd0;
            vector_q = BYTE_ZERO;
            dip_byte = BYTE_ZERO;
            seen     = 0;
            errors   = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function logic [7:0] decode_read(bus_access_t acc);
            logic [15:0] a;
            a = acc.address;
            if (a < TILE_BASE)  return (a < ROM_LIMIT) ? rom_img[a] : BYTE_OPEN_HIGH;
            if (a < PAL_BASE)   return tile_img[a - TILE_BASE];
            if (a < OPEN_BASE)  return palette_img[a - PAL_BASE];
            if (a < SCR_BASE)   return BYTE_OPEN_LOW;
            if (a < ATTR_BASE)  return scratch_img[a - SCR_BASE];
            if (a < PIN_A_BASE) return attr_img[a - ATTR_BASE];
            if (a < PIN_B_BASE) return acc.in_a;
            if (a < DIP_BASE)   return acc.in_b;
            if (a < HIGH_BASE)  return dip_byte;
            return BYTE_OPEN_HIGH;
        endfunction

        function void store_byte(logic [15:0] a, logic [7:0] d);
            if (a < TILE_BASE) return;
            if (a < PAL_BASE)   begin tile_img[a - TILE_BASE] = d; return; end
            if (a < OPEN_BASE)  begin palette_img[a - PAL_BASE] = d; return; end
            if (a < SCR_BASE) return;
            if (a < ATTR_BASE)  begin scratch_img[a - SCR_BASE] = d; return; end
            if (a < PIN_A_BASE) begin attr_img[a - ATTR_BASE] = d; return; end
            if (a <= LATCH_COIN_ADDR)
            begin
                case (a)
                    LATCH_IRQ_ADDR:  latch_q[0] = d[0];
                    LATCH_SND_ADDR:  latch_q[1] = d[0];
                    LATCH_FLIP_ADDR: latch_q[2] = d[0];
                    LATCH_COIN_ADDR: latch_q[3] = d[0];
                    default: ;
                endcase
                return;
            end
            if (a < PIN_B_BASE) return;
            if (a <= VOICE_END) begin voice_img[a - PIN_B_BASE] = 4'(d & NIBBLE_MASK); return; end
            if (a <= XY_END)    xy_img[a - XY_BASE] = d;
        endfunction

        function void note_access(bus_access_t acc);
            bus_result_t want;
            want.rd = BYTE_ZERO;
            case (acc.mode)
                MODE_MEM_RD: want.rd = decode_read(acc);
                MODE_MEM_WR: store_byte(acc.address, acc.wdata);
                MODE_IO_RD:  want.rd = BYTE_OPEN_HIGH;
                MODE_IO_WR:  if (acc.address[7:0] == VECTOR_PORT) vector_q = acc.wdata;
                MODE_ROM_LD: if (acc.address < ROM_LIMIT) rom_img[acc.address] = acc.wdata;
                default: ;
            endcase
            want.irq   = latch_q[0];
            want.audio = latch_q[1];
            want.flip  = latch_q[2];
            want.coin  = latch_q[3];
            want.vec   = vector_q;
            awaited.push_back(want);
        endfunction

        task flag_mismatch(string msg);
            if (errors < MAX_PRINTS) $display("mismatch at result %0d: %s", seen, msg);
            errors++;
        endtask

        task check_result(bus_result_t got);
            bus_result_t want;
            seen++;
            if (awaited.size() == 0)
            begin
                flag_mismatch("result with no access outstanding");
                return;
            end
            want = awaited.pop_front();
            if (got.rd !== want.rd)
                flag_mismatch($sformatf("read_data %h, expected %h", got.rd, want.rd));
            if (got.irq !== want.irq)
                flag_mismatch($sformatf("irq_enable %b, expected %b", got.irq, want.irq));
            if (got.audio !== want.audio)
                flag_mismatch($sformatf("audio_enable %b, expected %b", got.audio, want.audio));
            if (got.flip !== want.flip)
                flag_mismatch($sformatf("screen_flip %b, expected %b", got.flip, want.flip));
            if (got.coin !== want.coin)
                flag_mismatch($sformatf("coin_meter %b, expected %b", got.coin, want.coin));
            if (got.vec !== want.vec)
                flag_mismatch($sformatf("irq_vector %h, expected %h", got.vec, want.vec));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    abd_req_if bus_req ();
    abd_rsp_if bus_rsp ();

    arcade_bus_address_decoder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (bus_req),
        .rsp       (bus_rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    decoder_scoreboard sb;
    pace_t             pace;
    int                rsp_hold;
    int                cycle_count;

    // addresses whose storage has been written and may be read back
    bit          readable_map [0:65535];
    logic [15:0] readable_q [$];
    logic [15:0] last_written;

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 8'h00;
        bus_req.valid    = 1'b0;
        bus_req.mode     = 3'd0;
        bus_req.address  = 16'h0000;
        bus_req.write_data      = 8'h00;
        bus_req.player_inputs_a = 8'h00;
        bus_req.player_inputs_b = 8'h00;
        bus_rsp.ready    = 1'b0;
        pace             = PACE_STREAM;
        rsp_hold         = 0;
        sb               = new();
    end

    always #(CLK_HALF) clk = ~clk;

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("arcade_bus_address_decoder_unit regression: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic int idle_pct();
        case (pace)
            PACE_MIXED:  return 25;
            PACE_CHOKED: return 60;
            default:     return 0;
        endcase
    endfunction

    // result side: check every transfer, stall at random
    always @(posedge clk)
    begin : rsp_side
        bus_result_t got;
        if (rst_n === 1'b1 && bus_rsp.valid === 1'b1 && bus_rsp.ready === 1'b1)
        begin
            got.rd    = bus_rsp.read_data;
            got.irq   = bus_rsp.irq_enable;
            got.audio = bus_rsp.audio_enable;
            got.flip  = bus_rsp.screen_flip;
            got.coin  = bus_rsp.coin_meter;
            got.vec   = bus_rsp.irq_vector;
            sb.check_result(got);
        end
        if (rsp_hold > 0)
        begin
            rsp_hold--;
            bus_rsp.ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < idle_pct())
        begin
            rsp_hold = pick_gap() - 1;
            bus_rsp.ready <= 1'b0;
        end
        else
            bus_rsp.ready <= 1'b1;
    end

    // drive one access and hold it until the transfer
    task automatic issue_access(logic [2:0] m, logic [15:0] a, logic [7:0] d,
                                logic [7:0] pa, logic [7:0] pb);
        bus_access_t acc;
        acc = '{m, a, d, pa, pb};
        bus_req.mode            <= m;
        bus_req.address         <= a;
        bus_req.write_data      <= d;
        bus_req.player_inputs_a <= pa;
        bus_req.player_inputs_b <= pb;
        bus_req.valid           <= 1'b1;
        do @(posedge clk); while (bus_req.ready !== 1'b1);
        sb.note_access(acc);
        if ((m == MODE_ROM_LD && a < ROM_LIMIT) ||
            (m == MODE_MEM_WR && ((a >= TILE_BASE && a < OPEN_BASE) ||
                                  (a >= SCR_BASE && a < PIN_A_BASE))))
        begin
            if (!readable_map[a])
            begin
                readable_map[a] = 1'b1;
                readable_q.push_back(a);
            end
            last_written = a;
        end
    endtask

    task automatic bus_gap(int cycles);
        if (cycles > 0)
        begin
            bus_req.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        bus_req.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_dip(logic [7:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.dip_byte = value;
    endtask

    initial
    begin : stimulus
        int          pick;
        int          sub;
        int          span;
        logic [2:0]  m;
        logic [15:0] a;
        logic [15:0] base;
        logic [7:0]  d;
        logic [7:0]  dip;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_dip(8'h00);

        // directed: map edges, dropped writes, latch lines, io ports, spare modes
        issue_access(MODE_ROM_LD, 16'h0000, 8'h00, 8'h00, 8'h00);
        issue_access(MODE_ROM_LD, 16'h3FFF, 8'hFF, 8'hFF, 8'hFF);
        issue_access(MODE_MEM_WR, 16'h0000, 8'h5A, 8'h00, 8'h00);
        issue_access(MODE_MEM_RD, 16'h0000, 8'h00, 8'hFF, 8'h00);
        issue_access(MODE_MEM_RD, 16'h3FFF, 8'h00, 8'h00, 8'hFF);
        issue_access(MODE_MEM_WR, TILE_BASE, 8'hFF, 8'h00, 8'h00);
        issue_access(MODE_ROM_LD, TILE_BASE, 8'h77, 8'h00, 8'h00);
        issue_access(MODE_MEM_RD, TILE_BASE, 8'h00, 8'h00, 8'h00);
        issue_access(MODE_MEM_WR, OPEN_BASE - 16'd1, 8'h3C, 8'h00, 8'h00);
        issue_access(MODE_MEM_RD, OPEN_BASE, 8'h00, 8'h00, 8'h00);
        issue_access(MODE_MEM_WR, ATTR_BASE - 16'd1, 8'h80, 8'h00, 8'h00);
        issue_access(MODE_MEM_RD, ATTR_BASE - 16'd1, 8'h00, 8'h00, 8'h00);
        issue_access(MODE_MEM_RD, PIN_B_BASE - 16'd1, 8'h00, 8'hFF, 8'h00);
        issue_access(MODE_MEM_RD, PIN_B_BASE, 8'h00, 8'h00, 8'hFF);
        issue_access(MODE_MEM_RD, 16'hFFFF, 8'h00, 8'h00, 8'h00);
        issue_access(MODE_MEM_WR, LATCH_IRQ_ADDR, 8'h01, 8'h00, 8'h00);
        issue_access(MODE_MEM_WR, LATCH_SND_ADDR, 8'hFF, 8'h00, 8'h00);
        issue_access(MODE_MEM_WR, LATCH_COIN_ADDR, 8'h01, 8'h00, 8'h00);
        issue_access(MODE_MEM_WR, LATCH_SPARE, 8'h01, 8'h00, 8'h00);
        issue_access(MODE_MEM_WR, LATCH_IRQ_ADDR, 8'hFE, 8'h00, 8'h00);
        issue_access(MODE_MEM_WR, VOICE_END, 8'hFF, 8'h00, 8'h00);
        issue_access(MODE_IO_RD, 16'hFFFF, 8'h00, 8'h00, 8'h00);
        issue_access(MODE_IO_WR, 16'h1200, 8'hA5, 8'h00, 8'h00);
        issue_access(MODE_IO_WR, 16'h0001, 8'h3C, 8'h00, 8'h00);
        issue_access(MODE_SPARE_HI, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       dip = 8'hFF;
                2:       dip = 8'h00;
                4:       dip = 8'hA5;
                default: dip = 8'($urandom);
            endcase
            set_dip(dip);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % PACE_SPAN == 0) pace = pace_t'($urandom_range(0, 2));
                pick = $urandom_range(0, 99);
                sub  = $urandom_range(0, 3);
                d    = 8'($urandom);
                m    = MODE_MEM_RD;
                if (pick >= 40 && pick < 75 && readable_q.size() == 0) pick = 20;

                if (pick < 12)
                begin
                    m = MODE_ROM_LD;
                    a = (sub == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h01FF));
                end
                else if (pick < 32)
                begin
                    m = MODE_MEM_WR;
                    case (sub)
                        0:       begin base = TILE_BASE;  span = 1024; end
                        1:       begin base = PAL_BASE;   span = 1024; end
                        2:       begin base = SCR_BASE;   span = 1008; end
                        default: begin base = ATTR_BASE;  span = 16;   end
                    endcase
                    // half of the writes to the larger regions stay near the region base so reads revisit them
                    if ($urandom_range(0, 1) == 0 && span > 64) span = 64;
                    a = base + 16'($urandom_range(0, span - 1));
                end
                else if (pick < 40)
                begin
                    m = MODE_MEM_WR;
                    case ($urandom_range(0, 4))
                        0: a = 16'($urandom_range(PIN_A_BASE, LATCH_COIN_ADDR));
                        1: a = 16'($urandom_range(PIN_B_BASE, VOICE_END));
                        2: a = 16'($urandom_range(XY_BASE, XY_END));
                        3: a = sub[0] ? 16'($urandom_range(0, TILE_BASE - 1))
                                      : 16'($urandom_range(OPEN_BASE, SCR_BASE - 1));
                        default: a = sub[0]
                                      ? 16'($urandom_range(LATCH_COIN_ADDR + 1, PIN_B_BASE - 1))
                                      : 16'($urandom_range(XY_END + 1, 16'hFFFF));
                    endcase
                end
                else if (pick < 52)
                    a = last_written;
                else if (pick < 75)
                    a = readable_q[$urandom_range(0, readable_q.size() - 1)];
                else if (pick < 85)
                begin
                    case (sub)
                        0:       a = 16'($urandom_range(OPEN_BASE, SCR_BASE - 1));
                        1:       a = 16'($urandom_range(PIN_A_BASE, DIP_BASE - 1));
                        2:       a = 16'($urandom_range(DIP_BASE, HIGH_BASE - 1));
                        default: a = 16'($urandom_range(HIGH_BASE, 16'hFFFF));
                    endcase
                end
                else if (pick < 93)
                begin
                    m = sub[0] ? MODE_IO_RD : MODE_IO_WR;
                    a = 16'($urandom);
                    if (sub[1]) a[7:0] = VECTOR_PORT;
                end
                else
                begin
                    m = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
                    a = 16'($urandom);
                end

                issue_access(m, a, d, 8'($urandom), 8'($urandom));
                if ($urandom_range(0, 99) < idle_pct()) bus_gap(pick_gap());
            end
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("arcade_bus_address_decoder_unit regression: pass");
        else
            $display("arcade_bus_address_decoder_unit regression: fail");
        $finish;
    end

endmodule
